>>> sv/cfdd_pkg.sv
// ============================================================================
// cfdd_pkg: shared types and constants of the can frame dedup dictionary
// field widths, status codes and the sequencer state encoding
// ============================================================================
package cfdd_pkg;

   localparam int ID_W      = 29;
   localparam int LEN_W     = 4;
   localparam int FLAGS_W   = 8;
   localparam int PAYLOAD_W = 64;
   localparam int KEY_W     = ID_W + LEN_W + FLAGS_W;
   localparam int INDEX_W   = 8;
   localparam int COUNT_W   = 9;
   localparam int STATUS_W  = 2;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_FRAME_FULL = 2'd1;
   localparam status_type STATUS_ID_FULL    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FSCAN  = 4'b0010,
      ST_ISCAN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

>>> sv/can_frame_dedup_dictionary.sv
// ============================================================================
// can_frame_dedup_dictionary: table of unique can frames with id dictionary
// A frame transfer starts when start is high and busy is low. The block
// scans the unique-frame table for an entry equal in identifier, length
// code, flags and the stored payload bytes, then scans the identifier
// dictionary. A new frame is appended, together with its identifier when
// that is not yet known. A new frame that needs a slot in a full table
// gives an error status and changes nothing. req_first_in_sequence
// empties both tables first. Between accept and rsp_strobe the block
// makes two linear scans, through the frame ram and the id ram, one
// entry a cycle; a full frame table with no matching entry skips the id
// scan. busy is low again in the cycle rsp_strobe is high, so the next
// frame may be accepted there.
// Each result is shown for one cycle with rsp_strobe; the receiver cannot
// stall. Reset empties both tables at once (counts to zero), no clearing
// pass is needed.
// ============================================================================
module can_frame_dedup_dictionary #(
   parameter int FRAME_ENTRIES = 256,
   parameter int ID_ENTRIES    = 256,
   parameter int DATA_BYTES    = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_first_in_sequence,
   input  logic [cfdd_pkg::ID_W-1:0]       req_identifier,
   input  logic [cfdd_pkg::LEN_W-1:0]      req_length_code,
   input  logic [cfdd_pkg::FLAGS_W-1:0]    req_frame_flags,
   input  logic [cfdd_pkg::PAYLOAD_W-1:0]  req_payload,
   output logic                            rsp_strobe,
   output logic [cfdd_pkg::INDEX_W-1:0]    rsp_frame_index,
   output logic [cfdd_pkg::INDEX_W-1:0]    rsp_ident_slot,
   output logic                            rsp_new_frame,
   output cfdd_pkg::status_type            rsp_status,
   output logic [cfdd_pkg::COUNT_W-1:0]    rsp_frame_total,
   output logic [cfdd_pkg::COUNT_W-1:0]    rsp_unique_ids
);

   import cfdd_pkg::*;

   localparam int DATA_W  = 8 * DATA_BYTES;
   localparam int FWORD_W = KEY_W + DATA_W;
   localparam int FAW     = $clog2(FRAME_ENTRIES);
   localparam int IAW     = $clog2(ID_ENTRIES);
   localparam logic [COUNT_W-1:0] FRAME_MAX = COUNT_W'(FRAME_ENTRIES);
   localparam logic [COUNT_W-1:0] ID_MAX    = COUNT_W'(ID_ENTRIES);

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   frm_total_ff, frm_total_in;
   logic [COUNT_W-1:0]   ident_total_ff, ident_total_in;
   logic [COUNT_W-1:0]   idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [COUNT_W-1:0]   pend_idx_ff, pend_idx_in;
   logic                 frame_hit_ff, frame_hit_in;
   logic [COUNT_W-1:0]   frame_idx_ff, frame_idx_in;
   logic                 id_hit_ff, id_hit_in;
   logic [COUNT_W-1:0]   id_idx_ff, id_idx_in;

   logic [ID_W-1:0]      ident_ff, ident_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [FLAGS_W-1:0]   flags_ff, flags_in;
   logic [DATA_W-1:0]    data_ff, data_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [INDEX_W-1:0]   rsp_fidx_ff, rsp_fidx_in;
   logic [INDEX_W-1:0]   rsp_iidx_ff, rsp_iidx_in;
   logic                 rsp_new_ff, rsp_new_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_frames_ff, rsp_frames_in;
   logic [COUNT_W-1:0]   rsp_ids_ff, rsp_ids_in;

   logic                 accept;
   logic [FWORD_W-1:0]   frame_word;
   logic [FWORD_W-1:0]   frame_rdata;
   logic [ID_W-1:0]      id_rdata;
   logic                 frame_wr, id_wr;
   logic                 frame_match, id_match;

   assign accept     = start && (state_ff == ST_IDLE);
   assign frame_word = {ident_ff, len_ff, flags_ff, data_ff};
   assign frame_match = pend_ff && (frame_rdata == frame_word);
   assign id_match    = pend_ff && (id_rdata == ident_ff);

   cfdd_ram #(
      .WIDTH (FWORD_W),
      .DEPTH (FRAME_ENTRIES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_wr),
      .wr_addr (frm_total_ff[FAW-1:0]),
      .wr_data (frame_word),
      .rd_addr (idx_ff[FAW-1:0]),
      .rd_data (frame_rdata)
   );

   cfdd_ram #(
      .WIDTH (ID_W),
      .DEPTH (ID_ENTRIES)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (id_wr),
      .wr_addr (ident_total_ff[IAW-1:0]),
      .wr_data (ident_ff),
      .rd_addr (idx_ff[IAW-1:0]),
      .rd_data (id_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      frm_total_in   = frm_total_ff;
      ident_total_in = ident_total_ff;
      idx_in         = idx_ff;
      pend_in        = 1'b0;
      pend_idx_in    = idx_ff;
      frame_hit_in   = frame_hit_ff;
      frame_idx_in   = frame_idx_ff;
      id_hit_in      = id_hit_ff;
      id_idx_in      = id_idx_ff;
      ident_in       = ident_ff;
      len_in         = len_ff;
      flags_in       = flags_ff;
      data_in        = data_ff;
      rsp_strobe_in  = 1'b0;
      rsp_fidx_in    = rsp_fidx_ff;
      rsp_iidx_in    = rsp_iidx_ff;
      rsp_new_in     = rsp_new_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_frames_in  = rsp_frames_ff;
      rsp_ids_in     = rsp_ids_ff;
      frame_wr       = 1'b0;
      id_wr          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ident_in     = req_identifier;
               len_in       = req_length_code;
               flags_in     = req_frame_flags;
               data_in      = req_payload[DATA_W-1:0];
               frame_hit_in = 1'b0;
               frame_idx_in = '0;
               id_hit_in    = 1'b0;
               id_idx_in    = '0;
               idx_in       = '0;
               if (req_first_in_sequence) begin
                  frm_total_in   = '0;
                  ident_total_in = '0;
               end
               state_in = ST_FSCAN;
            end
         end
         ST_FSCAN: begin
            priority if (frame_match) begin
               frame_hit_in = 1'b1;
               frame_idx_in = pend_idx_ff;
               idx_in       = '0;
               state_in     = ST_ISCAN;
            end else if (!pend_ff && (idx_ff == frm_total_ff)) begin
               idx_in   = '0;
               state_in = (frm_total_ff == FRAME_MAX) ? ST_FINISH : ST_ISCAN;
            end else if (idx_ff < frm_total_ff) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_ISCAN: begin
            priority if (id_match) begin
               id_hit_in = 1'b1;
               id_idx_in = pend_idx_ff;
               state_in  = ST_FINISH;
            end else if (!pend_ff && (idx_ff == ident_total_ff)) begin
               state_in = ST_FINISH;
            end else if (idx_ff < ident_total_ff) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_fidx_in   = '0;
            rsp_iidx_in   = '0;
            rsp_new_in    = 1'b0;
            rsp_status_in = STATUS_OK;
            priority if (frame_hit_ff) begin
               rsp_fidx_in = frame_idx_ff[INDEX_W-1:0];
               rsp_iidx_in = id_hit_ff ? id_idx_ff[INDEX_W-1:0] : '0;
            end else if (frm_total_ff == FRAME_MAX) begin
               rsp_status_in = STATUS_FRAME_FULL;
            end else if (!id_hit_ff && (ident_total_ff == ID_MAX)) begin
               rsp_status_in = STATUS_ID_FULL;
            end else begin
               frame_wr       = 1'b1;
               id_wr          = !id_hit_ff;
               rsp_new_in     = 1'b1;
               rsp_fidx_in    = frm_total_ff[INDEX_W-1:0];
               rsp_iidx_in    = id_hit_ff ? id_idx_ff[INDEX_W-1:0]
                                          : ident_total_ff[INDEX_W-1:0];
               frm_total_in   = frm_total_ff + 1'b1;
               if (!id_hit_ff) begin
                  ident_total_in = ident_total_ff + 1'b1;
               end
            end
            rsp_frames_in = frm_total_in;
            rsp_ids_in    = ident_total_in;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frm_total_ff   <= '0;
         ident_total_ff <= '0;
         pend_ff        <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frm_total_ff   <= frm_total_in;
         ident_total_ff <= ident_total_in;
         pend_ff        <= pend_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pend_idx_ff   <= pend_idx_in;
      frame_hit_ff  <= frame_hit_in;
      frame_idx_ff  <= frame_idx_in;
      id_hit_ff     <= id_hit_in;
      id_idx_ff     <= id_idx_in;
      ident_ff      <= ident_in;
      len_ff        <= len_in;
      flags_ff      <= flags_in;
      data_ff       <= data_in;
      rsp_fidx_ff   <= rsp_fidx_in;
      rsp_iidx_ff   <= rsp_iidx_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frames_ff <= rsp_frames_in;
      rsp_ids_ff    <= rsp_ids_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_frame_index   = rsp_fidx_ff;
   assign rsp_ident_slot    = rsp_iidx_ff;
   assign rsp_new_frame     = rsp_new_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frame_total   = rsp_frames_ff;
   assign rsp_unique_ids    = rsp_ids_ff;

   // a result always appears with the sequencer back in idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not start a lookup");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != STATUS_OK) |->
         (!rsp_new_frame && (rsp_frame_index == '0) && (rsp_ident_slot == '0)))
      else $error("error result with nonzero indices");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (frm_total_ff <= FRAME_MAX) && (ident_total_ff <= ID_MAX)
         && (ident_total_ff <= frm_total_ff))
      else $error("table counts out of range");

   a_new_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_new_frame |->
         (rsp_frame_total == ({1'b0, rsp_frame_index} + 1'b1)))
      else $error("new frame not placed at end of table");

endmodule

>>> sv/cfdd_ram.sv
// ============================================================================
// cfdd_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ============================================================================
module cfdd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
